// ===== src/foot_contact_detector_top_defines.svh =====
// assertion helpers used by the checker file
`ifndef FOOT_CONTACT_DETECTOR_TOP_DEFINES_SVH
`define FOOT_CONTACT_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fdc_pkg.sv =====
package fdc_pkg;

  // foot state
  localparam int NUM_FEET = 2;
  localparam int FOOT_W   = (NUM_FEET > 1) ? $clog2(NUM_FEET) : 1;

  // field widths
  localparam int POS_W = 32;
  localparam int SPD_W = 32;
  localparam int DUS_W = 20;

  // datapath widths
  localparam int NUM_AXES = 3;
  localparam int AX_W     = 2;
  localparam int MAG_W    = POS_W;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int ROOT_W   = 34;
  localparam int SQ_W     = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int DIV_W    = ROOT_W + DUS_W;
  localparam int DEN_W    = DUS_W;
  localparam int SMOOTH_W = SPD_W + 3;
  localparam int RECIP_W  = 32;
  localparam int RPROD_W  = SMOOTH_W + RECIP_W;
  localparam int RECIP_SH = 34;
  localparam int CNT_W    = 6;

  // constants
  localparam logic [DUS_W-1:0] MIN_DELTA_US = 20'd100;
  localparam logic [DUS_W-1:0] US_PER_S     = 20'd1000000;
  localparam logic [SMOOTH_W-1:0] SMOOTH_DEN = 35'd5;
  // floor(2^34 / 5), estimate is low by at most one for sums below 5 * 2^32
  localparam logic [RECIP_W-1:0] SMOOTH_RECIP = 32'hcccccccc;

  // configuration registers
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANT_SPEED   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_SPEED = 4'd1;
  localparam logic [SPD_W-1:0] PLANT_SPEED_RST   = 32'd13107;
  localparam logic [SPD_W-1:0] RELEASE_SPEED_RST = 32'd32768;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified sample as queued for the back end
  typedef struct packed {
    logic                    side;
    logic                    foot_ok;
    logic                    short_frame;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [DUS_W-1:0]        dus;
  } fdc_item_t;

endpackage

// ===== src/fdc_in_if.sv =====
interface fdc_in_if import fdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    foot_side;
  logic signed [POS_W-1:0] ankle_x;
  logic signed [POS_W-1:0] ankle_y;
  logic signed [POS_W-1:0] ankle_z;
  logic [DUS_W-1:0]        delta_us;

  modport source (output valid, foot_side, ankle_x, ankle_y, ankle_z, delta_us,
                  input ready);
  modport sink (input valid, foot_side, ankle_x, ankle_y, ankle_z, delta_us,
                output ready);
endinterface

// ===== src/fdc_out_if.sv =====
interface fdc_out_if import fdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    side_out;
  logic                    is_planted;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] target_z;
  logic [SPD_W-1:0]        speed_out;

  modport source (output valid, side_out, is_planted, target_x, target_y, target_z,
                  speed_out, input ready);
  modport sink (input valid, side_out, is_planted, target_x, target_y, target_z,
                speed_out, output ready);
endinterface

// ===== src/fdc_cfg_if.sv =====
interface fdc_cfg_if import fdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/fdc_queue.sv =====
module fdc_queue import fdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  fdc_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output fdc_item_t pop_item
);

  fdc_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/fdc_front.sv =====
module fdc_front import fdc_pkg::*; (
  fdc_in_if.sink    in_if,
  output logic      push_valid,
  input  logic      push_ready,
  output fdc_item_t push_item
);

  // transaction goes straight into the queue when there is room
  assign push_valid = in_if.valid;
  assign in_if.ready = push_ready;

  // classify the sample: foot has state, frame long enough to measure
  always_comb begin
    push_item.side        = in_if.foot_side;
    push_item.foot_ok     = (int'(in_if.foot_side) < NUM_FEET);
    push_item.short_frame = (in_if.delta_us <= MIN_DELTA_US);
    push_item.x           = in_if.ankle_x;
    push_item.y           = in_if.ankle_y;
    push_item.z           = in_if.ankle_z;
    push_item.dus         = in_if.delta_us;
  end

endmodule

// ===== src/fdc_back.sv =====
module fdc_back import fdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  fdc_item_t  pop_item,
  fdc_cfg_if.sink    cfg_if,
  fdc_out_if.source  out_if
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_SQ, S_ACC, S_SQRT, S_SCALE, S_DIV, S_SMOOTH, S_RECIP, S_CORR, S_FIN
  } state_t;

  // magnitude of the difference of two signed positions
  function automatic logic [MAG_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                 input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  state_t              state_r;
  fdc_item_t           item_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MAG_W-1:0]    mag_r [NUM_AXES];
  logic [PROD_W-1:0]   prod_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]     sqop_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [DIV_W-1:0]    num_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    drem_r;
  logic [SMOOTH_W-1:0] ssum_r;
  logic [SPD_W-1:0]    squot_r;
  logic [SPD_W-1:0]    speed_r;
  logic [SPD_W-1:0]    plant_r;
  logic [SPD_W-1:0]    release_r;

  // per-foot state
  logic signed [POS_W-1:0] prev_x_r [NUM_FEET];
  logic signed [POS_W-1:0] prev_y_r [NUM_FEET];
  logic signed [POS_W-1:0] prev_z_r [NUM_FEET];
  logic                    have_prev_r [NUM_FEET];
  logic [SPD_W-1:0]        smooth_r [NUM_FEET];
  logic                    planted_r [NUM_FEET];
  logic signed [POS_W-1:0] lock_x_r [NUM_FEET];
  logic signed [POS_W-1:0] lock_y_r [NUM_FEET];
  logic signed [POS_W-1:0] lock_z_r [NUM_FEET];

  // result register
  logic                    out_valid_r;
  logic                    out_side_r;
  logic                    out_planted_r;
  logic signed [POS_W-1:0] out_x_r;
  logic signed [POS_W-1:0] out_y_r;
  logic signed [POS_W-1:0] out_z_r;
  logic [SPD_W-1:0]        out_speed_r;

  logic [FOOT_W-1:0]  foot_idx;
  logic [SUM_W-1:0]   sq_acc;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic               root_bit;
  logic [REM_W-1:0]   rem_nxt;
  logic [DEN_W:0]     drem_sh;
  logic [DEN_W:0]     den_ext;
  logic               qbit;
  logic [DEN_W-1:0]   drem_nxt;
  logic [DIV_W-1:0]   num_nxt;
  logic [SPD_W-1:0]   speed_sat;
  logic [DIV_W-1:0]   scale_prod;
  logic [SMOOTH_W-1:0] smooth_sum;
  logic [RPROD_W-1:0] recip_prod;
  logic [SMOOTH_W-1:0] five_q;
  logic [SMOOTH_W-1:0] srem;
  logic [SPD_W-1:0]   new_smooth;
  logic               planted_nxt;
  logic               lock_nxt;
  logic               out_free;

  assign foot_idx  = FOOT_W'(item_r.side);
  assign pop_ready = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  // sum of squares
  assign sq_acc = sum_r + SUM_W'(prod_r);

  // one root digit a cycle
  assign rem_sh   = {rem_r[REM_W-3:0], sqop_r[SQ_W-1 -: 2]};
  assign trial    = REM_W'({root_r, 2'b01});
  assign root_bit = (rem_sh >= trial);
  assign rem_nxt  = root_bit ? rem_sh - trial : rem_sh;

  // one quotient bit a cycle for the speed divide
  assign drem_sh  = {drem_r, num_r[DIV_W-1]};
  assign den_ext  = {1'b0, den_r};
  assign qbit     = (drem_sh >= den_ext);
  assign drem_nxt = DEN_W'(qbit ? drem_sh - den_ext : drem_sh);
  assign num_nxt  = {num_r[DIV_W-2:0], qbit};
  assign speed_sat = (|num_nxt[DIV_W-1:SPD_W]) ? '1 : num_nxt[SPD_W-1:0];

  // distance times microseconds per second
  assign scale_prod = root_r * US_PER_S;

  // 3*old + 2*new ahead of the divide by five
  assign smooth_sum = (SMOOTH_W'(smooth_r[foot_idx]) << 1) + SMOOTH_W'(smooth_r[foot_idx])
                    + (SMOOTH_W'(speed_r) << 1);

  // divide by five: reciprocal estimate, then one correction step
  assign recip_prod = ssum_r * SMOOTH_RECIP;
  assign five_q     = (SMOOTH_W'(squot_r) << 2) + SMOOTH_W'(squot_r);
  assign srem       = ssum_r - five_q;

  // hysteresis on the new smoothed speed
  assign new_smooth = squot_r;
  always_comb begin
    lock_nxt = 1'b0;
    if (planted_r[foot_idx]) begin
      planted_nxt = !(new_smooth > release_r);
    end else if (new_smooth < plant_r) begin
      planted_nxt = 1'b1;
      lock_nxt    = 1'b1;
    end else begin
      planted_nxt = 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_if.ready;

  // sequencer, foot state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      plant_r     <= PLANT_SPEED_RST;
      release_r   <= RELEASE_SPEED_RST;
      for (int i = 0; i < NUM_FEET; i++) begin
        prev_x_r[i]    <= '0;
        prev_y_r[i]    <= '0;
        prev_z_r[i]    <= '0;
        have_prev_r[i] <= 1'b0;
        smooth_r[i]    <= '0;
        planted_r[i]   <= 1'b0;
        lock_x_r[i]    <= '0;
        lock_y_r[i]    <= '0;
        lock_z_r[i]    <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CFG_PLANT_SPEED:   plant_r   <= cfg_if.data;
          CFG_RELEASE_SPEED: release_r <= cfg_if.data;
          default: ;
        endcase
      end

      // result taken and no new one loaded this cycle
      if (out_valid_r && out_if.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            item_r  <= pop_item;
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (!item_r.foot_ok) begin
            state_r <= S_FIN;
          end else if (have_prev_r[foot_idx] && !item_r.short_frame) begin
            mag_r[0] <= abs_diff(item_r.x, prev_x_r[foot_idx]);
            mag_r[1] <= abs_diff(item_r.y, prev_y_r[foot_idx]);
            mag_r[2] <= abs_diff(item_r.z, prev_z_r[foot_idx]);
            prod_r   <= '0;
            sum_r    <= '0;
            cnt_r    <= '0;
            state_r  <= S_SQ;
          end else begin
            speed_r <= '0;
            state_r <= S_SMOOTH;
          end
        end
        S_SQ: begin
          prod_r <= mag_r[cnt_r[AX_W-1:0]] * mag_r[cnt_r[AX_W-1:0]];
          sum_r  <= sq_acc;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_AXES - 1)) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          sqop_r  <= SQ_W'(sq_acc);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          rem_r  <= rem_nxt;
          root_r <= {root_r[ROOT_W-2:0], root_bit};
          sqop_r <= sqop_r << 2;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ROOT_W - 1)) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          num_r   <= scale_prod;
          den_r   <= item_r.dus;
          drem_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          num_r  <= num_nxt;
          drem_r <= drem_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_W - 1)) begin
            speed_r <= speed_sat;
            state_r <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          ssum_r  <= smooth_sum;
          state_r <= S_RECIP;
        end
        S_RECIP: begin
          squot_r <= recip_prod[RECIP_SH +: SPD_W];
          state_r <= S_CORR;
        end
        S_CORR: begin
          if (srem >= SMOOTH_DEN) begin
            squot_r <= squot_r + 1'b1;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_side_r  <= item_r.side;
            if (item_r.foot_ok) begin
              // commit foot state together with the result
              prev_x_r[foot_idx]    <= item_r.x;
              prev_y_r[foot_idx]    <= item_r.y;
              prev_z_r[foot_idx]    <= item_r.z;
              have_prev_r[foot_idx] <= 1'b1;
              smooth_r[foot_idx]    <= new_smooth;
              planted_r[foot_idx]   <= planted_nxt;
              out_planted_r         <= planted_nxt;
              out_speed_r           <= new_smooth;
              if (lock_nxt) begin
                lock_x_r[foot_idx] <= item_r.x;
                lock_y_r[foot_idx] <= item_r.y;
                lock_z_r[foot_idx] <= item_r.z;
                out_x_r            <= item_r.x;
                out_y_r            <= item_r.y;
                out_z_r            <= item_r.z;
              end else begin
                out_x_r <= lock_x_r[foot_idx];
                out_y_r <= lock_y_r[foot_idx];
                out_z_r <= lock_z_r[foot_idx];
              end
            end else begin
              out_planted_r <= 1'b0;
              out_speed_r   <= '0;
              out_x_r       <= '0;
              out_y_r       <= '0;
              out_z_r       <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.side_out   = out_side_r;
  assign out_if.is_planted = out_planted_r;
  assign out_if.target_x   = out_x_r;
  assign out_if.target_y   = out_y_r;
  assign out_if.target_z   = out_z_r;
  assign out_if.speed_out  = out_speed_r;

endmodule

// ===== src/foot_contact_detector_top.sv =====
// sequence: a foot without state goes from S_CLASS to S_FIN; a first sample or short
//   frame runs the 3-step divide by 5, a measured sample also a serial 34-step root and
//   54-step speed divide ahead of it; the back end takes a new sample only when done
//   with the last, while the front queues up to two more samples
// reset: rst_n synchronous, active low; clears foot state, queue and result valid flag,
//   loads default thresholds; no clearing pass, samples are taken right after reset
module foot_contact_detector_top import fdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fdc_in_if.sink    in_if,
  fdc_out_if.source out_if,
  fdc_cfg_if.sink   cfg_if
);

  logic      push_valid;
  logic      push_ready;
  fdc_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  fdc_item_t pop_item;

  // accept and classify
  fdc_front u_front (
    .in_if      (in_if),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  fdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // speed, smoothing and contact decision
  fdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg_if    (cfg_if),
    .out_if    (out_if)
  );

endmodule

// ===== src/fdc_checker.sv =====
`include "foot_contact_detector_top_defines.svh"

module fdc_checker import fdc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  fdc_out_if.source out_if,
  fdc_cfg_if.sink   cfg_if
);

  // stalled result keeps its transaction
  `FDC_ASSERT_NEXT(a_out_hold, out_if.valid && !out_if.ready, out_if.valid && $stable(out_if.side_out) && $stable(out_if.is_planted) && $stable(out_if.target_x) && $stable(out_if.target_y) && $stable(out_if.target_z) && $stable(out_if.speed_out), "result changed while stalled")

  // no result straight out of reset
  `FDC_ASSERT_NOW(a_out_reset, $rose(rst_n), !out_if.valid, "result valid right after reset")

  // configuration writes are never stalled
  `FDC_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_if.ready, "configuration port not ready")

endmodule

bind foot_contact_detector_top fdc_checker u_fdc_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_if (out_if),
  .cfg_if (cfg_if)
);
